>>> design/ckvt_pkg.sv
`default_nettype none

package ckvt_pkg;

	// Fixed field widths of the request and response items.
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 4;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 5;

	// Configuration register map.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FROZEN   = 1'b1;
	localparam logic [CNT_W-1:0]     CAPACITY_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_REGISTER   = 2'd0,
		CMD_DEREGISTER = 2'd1,
		CMD_LOOKUP     = 2'd2,
		CMD_GET_INDEX  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_ARG   = 3'd1,
		ST_BAD_STATE = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_READ,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

>>> design/compacting_key_value_table.sv
`default_nettype none

// Compacting key/value table. Up to min(capacity, DEPTH) pairs of key and value words are
// kept packed at positions 0 to entry_count-1 in insertion order, in two single-port-read
// memories. A request arrives as one transfer on the s_ side and always produces exactly one
// response transfer on the m_ side. Register (command 0) searches for a duplicate key and then
// appends; deregister (command 1) searches for the key and closes the gap by moving every later
// entry down one place; lookup (command 2) searches and returns the value; get by index
// (command 3) reads one position. All searches walk the stored entries through the one read
// port of the memories, one entry per cycle. A request that is refused on its arguments alone
// skips the memories and goes straight to the finish state. The response is loaded only once
// the output register is free, so a stall on the m_ side holds the block in that state. The
// next request can be taken in the cycle after its response is loaded. The block takes
// one request at a time: s_tready is high only while no request is in progress, although a
// finished response may still be waiting in the output register. Configuration (capacity,
// frozen) is written through the cfg_ port, which is always ready, and must only be written
// while no request is in progress.
module compacting_key_value_table
	import ckvt_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	// Stream payload layout, padded up to whole bytes.
	localparam int IN_W   = CMD_W + KEY_WIDTH + VALUE_WIDTH + IDX_W,
	localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = STATUS_W + KEY_WIDTH + VALUE_WIDTH + CNT_W + 1,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// Request stream.
	input  wire                       s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0 up: cmd, key, value, index, zero padding.
	input  wire  [IN_TW-1:0]          s_tdata,
	// Response stream.
	output logic                      m_tvalid,
	input  wire                       m_tready,
	// Fields from bit 0 up: status, out_key, out_value, entry_count, watermark_hit,
	// zero padding.
	output logic [OUT_TW-1:0]         m_tdata,
	// Configuration write channel.
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  [CFG_IDX_W-1:0]      cfg_index,
	input  wire  [CFG_DATA_W-1:0]     cfg_data
);

	localparam int KEY_LO = CMD_W;
	localparam int VAL_LO = KEY_LO + KEY_WIDTH;
	localparam int IDX_LO = VAL_LO + VALUE_WIDTH;

	// Memory address width and the width used for pointers and counts alike.
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam int CW = (PW > CNT_W) ? PW : CNT_W;

	// Request fields.
	cmd_t                   in_cmd;
	logic [KEY_WIDTH-1:0]   in_key;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [IDX_W-1:0]       in_index;

	assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign in_key   = s_tdata[KEY_LO +: KEY_WIDTH];
	assign in_value = s_tdata[VAL_LO +: VALUE_WIDTH];
	assign in_index = s_tdata[IDX_LO +: IDX_W];

	// Control state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  capacity_q;
	logic              frozen_q;
	logic [CNT_W-1:0]  stored_cnt_q;
	logic              wm_seen_q;
	logic              rd_vld_s1;
	logic              m_tvalid_q;

	// Payload of the request in progress.
	cmd_t                   cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	status_t                status_q;
	logic [KEY_WIDTH-1:0]   ok_key_q;
	logic [VALUE_WIDTH-1:0] ok_val_q;
	logic                   hit_q;
	logic [CW-1:0]          rd_ptr_q;
	logic [CW-1:0]          rd_addr_s1;

	// Response register.
	status_t                out_status_q;
	logic [KEY_WIDTH-1:0]   out_key_q;
	logic [VALUE_WIDTH-1:0] out_val_q;
	logic [CNT_W-1:0]       out_cnt_q;
	logic                   out_hit_q;

	// Entry memories with registered read data.
	logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
	logic [KEY_WIDTH-1:0]   key_rd_s1;
	logic [VALUE_WIDTH-1:0] val_rd_s1;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [KEY_WIDTH-1:0]   mem_wkey;
	logic [VALUE_WIDTH-1:0] mem_wval;

	// Derived conditions.
	logic          accept;
	logic          out_free;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] cap_eff;
	logic          key_match;
	logic          more;
	logic          drained;
	logic          has_room;
	logic          wm_fire;
	logic          early_done;
	status_t       early_status;

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;

	// The usable capacity never exceeds the memory depth.
	assign cnt_ext = CW'(stored_cnt_q);
	assign cap_eff = (CW'(capacity_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_q);

	assign key_match = rd_vld_s1 && (key_rd_s1 == key_q);
	assign more      = (rd_ptr_q < cnt_ext);
	assign drained   = !rd_vld_s1 && !more;
	assign has_room  = (cnt_ext < cap_eff);

	// The high watermark fires once, on the insert that leaves the count at capacity minus one.
	assign wm_fire = !wm_seen_q && (cap_eff != '0) &&
		(({1'b0, cnt_ext} + (CW+1)'(2)) == {1'b0, cap_eff});

	// Requests that are settled on their arguments alone, without touching the memories.
	always_comb begin
		early_done   = 1'b0;
		early_status = ST_OK;
		unique case (in_cmd)
			CMD_REGISTER: begin
				if (in_key == '0 || in_value == '0) begin
					early_done   = 1'b1;
					early_status = ST_BAD_ARG;
				end else if (frozen_q) begin
					early_done   = 1'b1;
					early_status = ST_BAD_STATE;
				end
			end
			CMD_DEREGISTER: begin
				if (in_key == '0) begin
					early_done   = 1'b1;
					early_status = ST_BAD_ARG;
				end else if (frozen_q) begin
					early_done   = 1'b1;
					early_status = ST_BAD_STATE;
				end
			end
			CMD_LOOKUP: begin
				if (in_key == '0) begin
					early_done   = 1'b1;
					early_status = ST_NOT_FOUND;
				end
			end
			CMD_GET_INDEX: begin
				if (CW'(in_index) >= cnt_ext) begin
					early_done   = 1'b1;
					early_status = ST_NOT_FOUND;
				end
			end
			default: begin
				early_done   = 1'b1;
				early_status = ST_NOT_FOUND;
			end
		endcase
	end

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (early_done) begin
						state_d = S_FINISH;
					end else if (in_cmd == CMD_GET_INDEX) begin
						state_d = S_READ;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (key_match) begin
					state_d = (cmd_q == CMD_DEREGISTER) ? S_SHIFT : S_FINISH;
				end else if (drained) begin
					state_d = S_FINISH;
				end
			end
			S_SHIFT: begin
				if (drained) begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer: memory port controls.
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = AW'(rd_ptr_q);
		mem_we    = 1'b0;
		mem_waddr = AW'(rd_addr_s1 - CW'(1));
		mem_wkey  = key_rd_s1;
		mem_wval  = val_rd_s1;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = accept;
				rd_addr = AW'(in_index);
			end
			S_SEARCH: begin
				rd_en = more && !key_match;
				// Append once the whole table has been searched without a duplicate.
				if (drained && cmd_q == CMD_REGISTER && has_room) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(cnt_ext);
					mem_wkey  = key_q;
					mem_wval  = val_q;
				end
			end
			S_SHIFT: begin
				// Each entry read in the previous cycle moves down one place.
				rd_en  = more;
				mem_we = rd_vld_s1;
			end
			S_READ, S_FINISH: begin
				rd_en = 1'b0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Entry memories.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_waddr] <= mem_wkey;
			val_mem[mem_waddr] <= mem_wval;
		end
		if (rd_en) begin
			key_rd_s1 <= key_mem[rd_addr];
			val_rd_s1 <= val_mem[rd_addr];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			capacity_q   <= CAPACITY_RESET;
			frozen_q     <= 1'b0;
			stored_cnt_q <= '0;
			wm_seen_q    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CAPACITY: capacity_q <= cfg_data;
					REG_FROZEN:   frozen_q   <= cfg_data[0];
					default:      frozen_q   <= frozen_q;
				endcase
			end

			rd_vld_s1 <= ((state_q == S_SEARCH && !key_match) || state_q == S_SHIFT) && more;

			if (state_q == S_SEARCH && drained && cmd_q == CMD_REGISTER && has_room) begin
				stored_cnt_q <= stored_cnt_q + CNT_W'(1);
				if (wm_fire) begin
					wm_seen_q <= 1'b1;
				end
			end else if (state_q == S_SHIFT && drained) begin
				stored_cnt_q <= stored_cnt_q - CNT_W'(1);
			end

			if (state_q == S_FINISH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request payload, search pointers and response payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q    <= in_cmd;
					key_q    <= in_key;
					val_q    <= in_value;
					status_q <= early_status;
					ok_key_q <= '0;
					ok_val_q <= '0;
					hit_q    <= 1'b0;
					rd_ptr_q <= '0;
				end
			end
			S_SEARCH: begin
				rd_addr_s1 <= rd_ptr_q;
				if (key_match) begin
					unique case (cmd_q)
						CMD_DEREGISTER: rd_ptr_q <= rd_addr_s1 + CW'(1);
						CMD_LOOKUP:     ok_val_q <= val_rd_s1;
						default:        status_q <= ST_BAD_STATE;
					endcase
				end else if (more) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end else if (drained) begin
					if (cmd_q != CMD_REGISTER) begin
						status_q <= ST_NOT_FOUND;
					end else if (!has_room) begin
						status_q <= ST_NO_SPACE;
					end else begin
						hit_q <= wm_fire;
					end
				end
			end
			S_SHIFT: begin
				rd_addr_s1 <= rd_ptr_q;
				if (more) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
			end
			S_READ: begin
				ok_key_q <= key_rd_s1;
				ok_val_q <= val_rd_s1;
			end
			S_FINISH: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_key_q    <= ok_key_q;
					out_val_q    <= ok_val_q;
					out_cnt_q    <= stored_cnt_q;
					out_hit_q    <= hit_q;
				end
			end
			default: begin
				rd_addr_s1 <= rd_addr_s1;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'({out_hit_q, out_cnt_q, out_val_q, out_key_q, out_status_q});

	// The table never holds more entries than the memory has places.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= CW'(DEPTH))
		else $error("entry count exceeds table depth");

	// Once raised, the watermark mark stays for good.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wm_seen_q))
		else $error("watermark mark cleared");

	// A watermark response is always a successful insert.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && out_hit_q) |-> (out_status_q == ST_OK))
		else $error("watermark reported on a refused request");

	// The count moves by at most one entry per request and only while one is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stored_cnt_q != $past(stored_cnt_q)) |->
		($past(state_q) == S_SEARCH || $past(state_q) == S_SHIFT))
		else $error("entry count changed outside a register or deregister");

	// A memory write never targets a position at or beyond the stored entries plus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= cnt_ext))
		else $error("memory write beyond the packed entries");

endmodule

`default_nettype wire
